@@ src/hermite_fractional_delay_line_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Hermite fractional delay line
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HERMITE_FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH
`define HERMITE_FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HFDL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hfdl: check failed");
`define HFDL_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("hfdl: forbidden condition seen");
`else
`define HFDL_ASSERT(lbl, clk, rst_n, prop)
`define HFDL_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

@@ src/hfdl_pkg.sv @@
// ----------------------------------------------------------------------------
// Hermite fractional delay line package
// Shared port widths, mode codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package hfdl_pkg;

  localparam int unsigned POS_BITS       = 16;
  localparam int unsigned FRAC_IO_BITS   = 16;
  localparam int unsigned SAMPLE_IO_BITS = 24;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [1:0] LAST_TAP  = 2'd3;
  localparam logic [1:0] LAST_STEP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_COEF,
    ST_STEP,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic en;
    logic we;
  } ring_cmd_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic step;
  } hrn_ctrl_t;

endpackage

@@ src/hfdl_ring.sv @@
// ----------------------------------------------------------------------------
// Sample ring memory
// Single-port synchronous RAM with registered read data and a clearing
// sweep that zeroes every entry after reset.
// ----------------------------------------------------------------------------
`include "hermite_fractional_delay_line_core_assert.svh"

module hfdl_ring #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 24,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hfdl_pkg::ring_cmd_t cmd_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  output logic [WIDTH-1:0]    rdata_o,
  output logic                rvalid_o,
  output logic                busy_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             busy_q, busy_d;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    wr_addr;
  logic [WIDTH-1:0] wr_data;

  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // the sweep owns the port until every entry is zero
  assign wr_en   = busy_q | (cmd_i.en & cmd_i.we);
  assign rd_en   = ~busy_q & cmd_i.en & ~cmd_i.we;
  assign wr_addr = busy_q ? clr_addr_q : addr_i;
  assign wr_data = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
      rvalid_q   <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
      rvalid_q   <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;
  assign busy_o   = busy_q;

  `HFDL_ASSERT_NEVER(a_cmd_during_clear, clk_i, rst_ni, busy_q && cmd_i.en)
  `HFDL_ASSERT(a_clear_ends_at_top, clk_i, rst_ni,
               $fell(busy_q) |-> $past(clr_addr_q) == AW'(DEPTH - 1))
  `HFDL_ASSERT(a_read_after_clear, clk_i, rst_ni, rvalid_q |-> !$past(busy_q))

endmodule

@@ src/hfdl_horner.sv @@
// ----------------------------------------------------------------------------
// Hermite interpolation datapath
// Collects four neighbor samples, forms the twice-scaled cubic coefficients
// and runs one Horner multiply-round-add per step, then rounds and saturates.
// ----------------------------------------------------------------------------
module hfdl_horner #(
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  hfdl_pkg::hrn_ctrl_t                 ctrl_i,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  logic [hfdl_pkg::FRAC_IO_BITS-1:0]   fraction_i,
  output logic [SAMPLE_BITS-1:0]              result_o
);

  import hfdl_pkg::*;

  localparam int unsigned FW  = (FRACTION_BITS < FRAC_IO_BITS) ? FRACTION_BITS
                                                                : FRAC_IO_BITS;
  localparam int unsigned KW  = SAMPLE_BITS + 4;
  localparam int unsigned ACW = SAMPLE_BITS + 5;
  localparam int unsigned PW  = ACW + FW + 1;
  localparam int unsigned UW  = ACW - SAMPLE_BITS + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] tap_q [4];
  logic signed [KW-1:0]          kadd_q [3];
  logic signed [ACW-1:0]         acc_q;
  logic signed [KW-1:0]          e0, e1, e2, e3, d12;
  logic signed [KW-1:0]          k0, k1, k2, k3;
  logic signed [FW:0]            frac_s;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          prod_rnd;
  logic signed [ACW-1:0]         acc_d;
  logic signed [ACW-1:0]         inc_w;
  logic signed [ACW-1:0]         half_w;
  logic [UW-1:0]                 upper;

  always_comb begin
    e0  = {{(KW - SAMPLE_BITS){tap_q[0][SAMPLE_BITS-1]}}, tap_q[0]};
    e1  = {{(KW - SAMPLE_BITS){tap_q[1][SAMPLE_BITS-1]}}, tap_q[1]};
    e2  = {{(KW - SAMPLE_BITS){tap_q[2][SAMPLE_BITS-1]}}, tap_q[2]};
    e3  = {{(KW - SAMPLE_BITS){tap_q[3][SAMPLE_BITS-1]}}, tap_q[3]};
    d12 = e1 - e2;
    k0  = e1 <<< 1;
    k1  = e2 - e0;
    k2  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    k3  = (e3 - e0) + d12 + (d12 <<< 1);
  end

  // one multiply per step, round half up, then add the next coefficient
  assign frac_s   = {1'b0, fraction_i[FW-1:0]};
  assign prod     = PW'(acc_q) * PW'(frac_s);
  assign prod_rnd = (prod + HALF) >>> FRACTION_BITS;
  assign acc_d    = prod_rnd[ACW-1:0] + {kadd_q[2][KW-1], kadd_q[2]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      tap_q[0] <= tap_q[1];
      tap_q[1] <= tap_q[2];
      tap_q[2] <= tap_q[3];
      tap_q[3] <= sample_i;
    end
    if (ctrl_i.load) begin
      acc_q     <= {k3[KW-1], k3};
      kadd_q[2] <= k2;
      kadd_q[1] <= k1;
      kadd_q[0] <= k0;
    end else if (ctrl_i.step) begin
      acc_q     <= acc_d;
      kadd_q[2] <= kadd_q[1];
      kadd_q[1] <= kadd_q[0];
    end
  end

  // undo the factor of two, round half up, clamp to full scale
  assign inc_w  = acc_q + ACW'(1);
  assign half_w = inc_w >>> 1;
  assign upper  = half_w[ACW-1:SAMPLE_BITS-1];

  always_comb begin
    if (upper == '0 || upper == '1) begin
      result_o = half_w[SAMPLE_BITS-1:0];
    end else if (half_w[ACW-1]) begin
      result_o = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

endmodule

@@ src/hermite_fractional_delay_line_core.sv @@
// ----------------------------------------------------------------------------
// Hermite fractional delay line core
// A ring of RING_DEPTH samples in one single-port RAM. A write request
// stores sample_in at position and is taken with no result. A read
// request fetches the entries at position-1 .. position+2 (wrapping) one
// per cycle, then runs three Horner steps of the 4-point Hermite cubic on
// a shared multiplier. Its result is registered as the read leaves its
// rounding state, and the next request is taken the cycle after that, so
// a read holds off new requests until its result is registered. It
// passes through the four RAM reads, a drain of the last read, a
// coefficient load, the three dependent multiply steps and a rounding
// step; a previous result still waiting in the output register holds the
// read in its rounding cycle. After reset the RAM is zeroed by a sweep
// over all RING_DEPTH entries, during which in_ready stays low. A finished
// result waits in the output register while new requests are taken.
// ----------------------------------------------------------------------------
`include "hermite_fractional_delay_line_core_assert.svh"

module hermite_fractional_delay_line_core #(
  parameter int unsigned RING_DEPTH    = 65536,
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     mode_i,
  input  logic [hfdl_pkg::POS_BITS-1:0]            position_i,
  input  logic [hfdl_pkg::FRAC_IO_BITS-1:0]        fraction_i,
  input  logic signed [hfdl_pkg::SAMPLE_IO_BITS-1:0] sample_in_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [hfdl_pkg::SAMPLE_IO_BITS-1:0] sample_out_o
);

  import hfdl_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);

  state_e                   state_q, state_d;
  logic [1:0]               tap_q, tap_d;
  logic [1:0]               step_q, step_d;
  logic [AW-1:0]            base_q, base_d;
  logic [FRAC_IO_BITS-1:0]  frac_q, frac_d;
  logic                     out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]   out_data_q;
  logic                     load_out;
  logic                     in_accept;
  logic                     out_free;
  logic [AW-1:0]            pos_ext;

  ring_cmd_t                ring_cmd;
  logic [AW-1:0]            ring_addr;
  logic [SAMPLE_BITS-1:0]   ring_wdata;
  logic [SAMPLE_BITS-1:0]   ring_rdata;
  logic                     ring_rvalid;
  logic                     ring_busy;

  hrn_ctrl_t                hrn_ctrl;
  logic [SAMPLE_BITS-1:0]   hrn_result;

  assign in_accept  = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign pos_ext    = AW'(position_i);
  assign ring_wdata = SAMPLE_BITS'($unsigned(sample_in_i));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && mode_i == MODE_READ) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (tap_q == LAST_TAP) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_COEF;
      ST_COEF:  state_d = ST_STEP;
      ST_STEP: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    ring_cmd       = '0;
    ring_addr      = base_q + AW'(tap_q) - AW'(1);
    hrn_ctrl       = '0;
    hrn_ctrl.shift = ring_rvalid;
    tap_d          = tap_q;
    step_d         = step_q;
    base_d         = base_q;
    frac_d         = frac_q;
    load_out       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = ~ring_busy;
        // a read starts with its left neighbor in the accept cycle
        ring_addr  = (mode_i == MODE_READ) ? pos_ext - AW'(1) : pos_ext;
        if (in_accept) begin
          ring_cmd.en = 1'b1;
          ring_cmd.we = (mode_i == MODE_WRITE);
          base_d      = pos_ext;
          frac_d      = fraction_i;
          tap_d       = 2'd1;
          step_d      = '0;
        end
      end
      ST_FETCH: begin
        ring_cmd.en = 1'b1;
        tap_d       = tap_q + 2'd1;
      end
      ST_DRAIN: begin
        ring_cmd = '0;
      end
      ST_COEF: begin
        hrn_ctrl.load = 1'b1;
      end
      ST_STEP: begin
        hrn_ctrl.step = 1'b1;
        step_d        = step_q + 2'd1;
      end
      ST_ROUND: begin
        load_out = out_free;
      end
      default: begin
        ring_cmd = '0;
      end
    endcase
  end

  // hold the result until taken
  assign out_valid_d = load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    frac_q <= frac_d;
    if (load_out) begin
      out_data_q <= hrn_result;
    end
  end

  hfdl_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ring_cmd),
    .addr_i   (ring_addr),
    .wdata_i  (ring_wdata),
    .rdata_o  (ring_rdata),
    .rvalid_o (ring_rvalid),
    .busy_o   (ring_busy)
  );

  hfdl_horner #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_horner (
    .clk_i      (clk_i),
    .ctrl_i     (hrn_ctrl),
    .sample_i   (ring_rdata),
    .fraction_i (frac_q),
    .result_o   (hrn_result)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = SAMPLE_IO_BITS'(out_data_q);

  `HFDL_ASSERT(a_read_starts_fetch, clk_i, rst_ni,
               in_accept && mode_i == MODE_READ |=> state_q == ST_FETCH && tap_q == 2'd1)
  `HFDL_ASSERT(a_last_tap_in_drain, clk_i, rst_ni, state_q == ST_DRAIN |-> ring_rvalid)
  `HFDL_ASSERT_NEVER(a_tap_after_coef, clk_i, rst_ni, state_q == ST_COEF && ring_rvalid)
  `HFDL_ASSERT(a_result_from_round, clk_i, rst_ni,
               $rose(out_valid_q) |-> $past(state_q) == ST_ROUND)
  `HFDL_ASSERT(a_round_after_steps, clk_i, rst_ni,
               state_q == ST_ROUND |-> $past(state_q) == ST_STEP || $past(state_q) == ST_ROUND)

endmodule
